// File: hw/rtl/gbi_pkg.sv
// Shared constants and types for the grid bilinear interpolator.
// Depends on nothing; gbi_axis_split, gbi_blend and the top level import it.
package gbi_pkg;

   localparam int DEF_MAX_COLS    = 128;
   localparam int DEF_MAX_ROWS    = 128;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int CFG_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CELL_IDX_W = 7;
   localparam int IN_SAMPLE_W = 16;
   localparam int OUT_W      = 16;
   localparam int FRAC_W     = 17;
   localparam int FRAC_BITS  = 16;
   localparam int REQ_DATA_W = 64;

   // Widest axis index and count over the supported grid sizes.
   localparam int AXIS_IDX_W = 10;
   localparam int AXIS_CNT_W = 11;
   localparam int WEIGHT_W   = 33;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h1_0000;
   localparam logic [CFG_W-1:0]  CFG_RESET = 8'd128;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS    = 1'd1;

   typedef struct packed {
      logic [AXIS_IDX_W-1:0] lo;
      logic [AXIS_IDX_W-1:0] hi;
      logic [FRAC_BITS-1:0]  frac;
   } axis_split_type;

endpackage

// File: hw/rtl/gbi_ram.sv
// Generic single-port RAM with a registered, read-first output.
// Depends on nothing; one instance per grid bank.
module gbi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end

endmodule

// File: hw/rtl/gbi_axis_split.sv
// Splits one normalized coordinate into low and high cell indexes and a fraction.
// Depends on gbi_pkg for widths and the split struct.
module gbi_axis_split import gbi_pkg::*; (
   input  logic [FRAC_W-1:0]     frac,
   input  logic [AXIS_CNT_W-1:0] count,
   output axis_split_type        split
);

   logic [AXIS_IDX_W-1:0]        last;
   logic [FRAC_W-1:0]            frac_clamped;
   logic [AXIS_IDX_W+FRAC_W-1:0] scaled;
   logic [AXIS_CNT_W-1:0]        lo_raw;

   always_comb begin
      last         = AXIS_IDX_W'(count - AXIS_CNT_W'(1));
      frac_clamped = (frac > FRAC_ONE) ? FRAC_ONE : frac;
      scaled       = (AXIS_IDX_W+FRAC_W)'(last) * (AXIS_IDX_W+FRAC_W)'(frac_clamped);
      lo_raw       = scaled[AXIS_IDX_W+FRAC_W-1:FRAC_BITS];
      if (lo_raw >= {1'b0, last}) begin
         split.lo   = last;
         split.hi   = last;
         split.frac = '0;
      end else begin
         split.lo   = lo_raw[AXIS_IDX_W-1:0];
         split.hi   = lo_raw[AXIS_IDX_W-1:0] + AXIS_IDX_W'(1);
         split.frac = scaled[FRAC_BITS-1:0];
      end
   end

endmodule

// File: hw/rtl/gbi_blend.sv
// Weighted sum of four corners: multiply, add in pairs, round and saturate.
// Depends on gbi_pkg; drives the result channel from its own output register.
module gbi_blend import gbi_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [3:0][SAMPLE_BITS-1:0]       in_corner,
   input  logic [3:0][WEIGHT_W-1:0]          in_weight,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [OUT_W-1:0]                  rsp_tdata
);

   localparam int PROD_W = SAMPLE_BITS + WEIGHT_W + 1;
   localparam int PAIR_W = PROD_W + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - 32;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd2147483648);
   localparam logic signed [63:0] OUT_MAX = 64'sd32767;
   localparam logic signed [63:0] OUT_MIN = -64'sd32768;

   logic                                   c_valid_ff, c_valid_in;
   logic                                   d_valid_ff, d_valid_in;
   logic                                   e_valid_ff, e_valid_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   ready_c, ready_d, ready_e, ready_out;

   logic [3:0][SAMPLE_BITS-1:0]            c_corner_ff;
   logic [3:0][WEIGHT_W-1:0]               c_weight_ff;
   logic signed [PROD_W-1:0]               d_prod_ff [4];
   logic signed [PROD_W-1:0]               d_prod_in [4];
   logic signed [PAIR_W-1:0]               e_pair_ff [2];
   logic signed [PAIR_W-1:0]               e_pair_in [2];
   logic signed [ACC_W-1:0]                acc_sum;
   logic signed [RND_W-1:0]                rnd;
   logic signed [63:0]                     rnd_wide;
   logic [OUT_W-1:0]                       rsp_data_ff, rsp_data_in;

   always_comb begin
      ready_out = !rsp_valid_ff || rsp_tready;
      ready_e   = !e_valid_ff || ready_out;
      ready_d   = !d_valid_ff || ready_e;
      ready_c   = !c_valid_ff || ready_d;
      in_ready  = ready_c;

      c_valid_in   = (in_valid && ready_c) || (c_valid_ff && !ready_d);
      d_valid_in   = (c_valid_ff && ready_d) || (d_valid_ff && !ready_e);
      e_valid_in   = (d_valid_ff && ready_e) || (e_valid_ff && !ready_out);
      rsp_valid_in = (e_valid_ff && ready_out) || (rsp_valid_ff && !rsp_tready);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         d_prod_in[k] = PROD_W'($signed(c_corner_ff[k]))
                      * PROD_W'($signed({1'b0, c_weight_ff[k]}));
      end
      e_pair_in[0] = PAIR_W'(d_prod_ff[0]) + PAIR_W'(d_prod_ff[1]);
      e_pair_in[1] = PAIR_W'(d_prod_ff[2]) + PAIR_W'(d_prod_ff[3]);

      acc_sum  = ACC_W'(e_pair_ff[0]) + ACC_W'(e_pair_ff[1]) + ROUND_HALF;
      rnd      = RND_W'(acc_sum >>> 32);
      rnd_wide = 64'(rnd);
      if (rnd_wide > OUT_MAX) begin
         rsp_data_in = OUT_W'(OUT_MAX);
      end else if (rnd_wide < OUT_MIN) begin
         rsp_data_in = OUT_W'(OUT_MIN);
      end else begin
         rsp_data_in = OUT_W'(rnd_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         d_valid_ff   <= d_valid_in;
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_c) begin
         c_corner_ff <= in_corner;
         c_weight_ff <= in_weight;
      end
      if (c_valid_ff && ready_d) begin
         d_prod_ff <= d_prod_in;
      end
      if (d_valid_ff && ready_e) begin
         e_pair_ff <= e_pair_in;
      end
      if (e_valid_ff && ready_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hw/rtl/grid_bilinear_interpolator.sv
// Top level of the grid bilinear interpolator: configuration, four grid banks, pipeline.
// Depends on gbi_pkg, gbi_ram, gbi_axis_split and gbi_blend.
//
// The grid sits in four single-port RAM banks split by row and column parity, so
// the four corners of any query come out of one access, one per bank. A word with
// tuser 0 writes one cell; a word with tuser 1 is a query that returns one result.
// Both kinds are taken at one word per clock while req_tready is high; a query's result
// passes through the address register, the bank read, the blend input register,
// the weight products, the pair sums and the output register. The grid contents
// are undefined until written and there is no clearing pass after reset. Writes
// and reads reach the banks in arrival order, so a query sees every earlier write.
module grid_bilinear_interpolator import gbi_pkg::*; #(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cell_row[6:0], cell_col[13:7], cell_value[29:14], x_frac[46:30], y_frac[63:47]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // interp_value[15:0]
   output logic [OUT_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int RHW        = (ROW_BITS > 1) ? ROW_BITS - 1 : 1;
   localparam int CHW        = (COL_BITS > 1) ? COL_BITS - 1 : 1;
   localparam int BAW        = RHW + CHW;
   localparam int BANK_DEPTH = 1 << BAW;
   localparam logic signed [63:0] SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;

   logic [CFG_W-1:0]            num_columns_ff, num_rows_ff;
   logic [AXIS_CNT_W-1:0]       col_count, row_count;

   logic [CELL_IDX_W-1:0]       req_row, req_col;
   logic signed [IN_SAMPLE_W-1:0] req_value;
   logic [FRAC_W-1:0]           req_x, req_y;
   axis_split_type              x_split, y_split;

   logic                        wr_ok;
   logic [1:0]                  wr_bank;
   logic [BAW-1:0]              wr_addr;
   logic signed [63:0]          value_wide;
   logic [AXIS_IDX_W-1:0]       row_sel, col_sel;

   logic                        req_go, a_go, b_go, ready_b, blend_ready;
   logic                        a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic                        a_cmd_ff;
   logic [3:0][BAW-1:0]         a_addr_ff, a_addr_in;
   logic [3:0]                  a_bank_we_ff, a_bank_we_in;
   logic [SAMPLE_BITS-1:0]      a_wdata_ff, a_wdata_in;
   logic [3:0]                  a_par_ff, a_par_in;
   logic [FRAC_BITS-1:0]        a_fx_ff, a_fy_ff;
   logic [3:0]                  b_par_ff;
   logic [FRAC_BITS-1:0]        b_fx_ff, b_fy_ff;

   logic [3:0][SAMPLE_BITS-1:0] bank_rdata;
   logic [3:0]                  bank_we;
   logic [3:0][SAMPLE_BITS-1:0] corner;
   logic [3:0][WEIGHT_W-1:0]    weight;
   logic [FRAC_W-1:0]           wx0, wy0, fx, fy;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff <= CFG_RESET;
         num_rows_ff    <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_COLUMNS: num_columns_ff <= csr_wdata;
            CSR_NUM_ROWS:    num_rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_columns_ff == '0) begin
         col_count = AXIS_CNT_W'(1);
      end else if (32'(num_columns_ff) > 32'(MAX_COLS)) begin
         col_count = AXIS_CNT_W'(MAX_COLS);
      end else begin
         col_count = AXIS_CNT_W'(num_columns_ff);
      end
      if (num_rows_ff == '0) begin
         row_count = AXIS_CNT_W'(1);
      end else if (32'(num_rows_ff) > 32'(MAX_ROWS)) begin
         row_count = AXIS_CNT_W'(MAX_ROWS);
      end else begin
         row_count = AXIS_CNT_W'(num_rows_ff);
      end
   end

   assign req_row   = req_tdata[6:0];
   assign req_col   = req_tdata[13:7];
   assign req_value = $signed(req_tdata[29:14]);
   assign req_x     = req_tdata[46:30];
   assign req_y     = req_tdata[63:47];

   gbi_axis_split u_x_split (
      .frac  (req_x),
      .count (col_count),
      .split (x_split)
   );

   gbi_axis_split u_y_split (
      .frac  (req_y),
      .count (row_count),
      .split (y_split)
   );

   // Bank b holds cells whose row parity is b[1] and column parity is b[0].
   always_comb begin
      wr_ok      = (32'(req_row) < 32'(MAX_ROWS)) && (32'(req_col) < 32'(MAX_COLS));
      wr_bank    = {req_row[0], req_col[0]};
      wr_addr    = {RHW'(req_row >> 1), CHW'(req_col >> 1)};
      value_wide = 64'(req_value);
      if (value_wide > SAMPLE_MAX) begin
         a_wdata_in = SAMPLE_BITS'(SAMPLE_MAX);
      end else if (value_wide < SAMPLE_MIN) begin
         a_wdata_in = SAMPLE_BITS'(SAMPLE_MIN);
      end else begin
         a_wdata_in = SAMPLE_BITS'(value_wide);
      end
      a_par_in = {y_split.hi[0], y_split.lo[0], x_split.hi[0], x_split.lo[0]};
      row_sel  = '0;
      col_sel  = '0;
      for (int b = 0; b < 4; b++) begin
         row_sel = (y_split.lo[0] == b[1]) ? y_split.lo : y_split.hi;
         col_sel = (x_split.lo[0] == b[0]) ? x_split.lo : x_split.hi;
         if (req_tuser == CMD_WRITE) begin
            a_addr_in[b]    = wr_addr;
            a_bank_we_in[b] = wr_ok && (wr_bank == 2'(b));
         end else begin
            a_addr_in[b]    = {RHW'(row_sel >> 1), CHW'(col_sel >> 1)};
            a_bank_we_in[b] = 1'b0;
         end
      end
   end

   always_comb begin
      ready_b    = !b_valid_ff || blend_ready;
      b_go       = b_valid_ff && blend_ready;
      a_go       = a_valid_ff && ready_b;
      req_tready = !a_valid_ff || ready_b;
      req_go     = req_tvalid && req_tready;
      a_valid_in = req_go || (a_valid_ff && !a_go);
      b_valid_in = a_go ? (a_cmd_ff == CMD_QUERY) : (b_valid_ff && !b_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         a_cmd_ff     <= req_tuser;
         a_addr_ff    <= a_addr_in;
         a_bank_we_ff <= a_bank_we_in;
         a_wdata_ff   <= a_wdata_in;
         a_par_ff     <= a_par_in;
         a_fx_ff      <= x_split.frac;
         a_fy_ff      <= y_split.frac;
      end
      if (a_go) begin
         b_par_ff <= a_par_ff;
         b_fx_ff  <= a_fx_ff;
         b_fy_ff  <= a_fy_ff;
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      assign bank_we[g] = a_go && a_bank_we_ff[g];

      gbi_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock (clock),
         .en    (a_go),
         .we    (bank_we[g]),
         .addr  (a_addr_ff[g]),
         .wdata (a_wdata_ff),
         .rdata (bank_rdata[g])
      );
   end

   // Corner order: low x low y, high x low y, low x high y, high x high y.
   always_comb begin
      corner[0] = bank_rdata[{b_par_ff[2], b_par_ff[0]}];
      corner[1] = bank_rdata[{b_par_ff[2], b_par_ff[1]}];
      corner[2] = bank_rdata[{b_par_ff[3], b_par_ff[0]}];
      corner[3] = bank_rdata[{b_par_ff[3], b_par_ff[1]}];
      fx        = {1'b0, b_fx_ff};
      fy        = {1'b0, b_fy_ff};
      wx0       = FRAC_ONE - fx;
      wy0       = FRAC_ONE - fy;
      weight[0] = WEIGHT_W'(wx0) * WEIGHT_W'(wy0);
      weight[1] = WEIGHT_W'(fx) * WEIGHT_W'(wy0);
      weight[2] = WEIGHT_W'(wx0) * WEIGHT_W'(fy);
      weight[3] = WEIGHT_W'(fx) * WEIGHT_W'(fy);
   end

   gbi_blend #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_ready   (blend_ready),
      .in_corner  (corner),
      .in_weight  (weight),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_query_reaches_read: assert property (@(posedge clock) disable iff (reset)
      (a_go && a_cmd_ff == CMD_QUERY) |=> b_valid_ff)
      else $error("A query leaving the address stage did not reach the read stage.");

   a_write_makes_no_read: assert property (@(posedge clock) disable iff (reset)
      (a_go && a_cmd_ff == CMD_WRITE) |=> !b_valid_ff)
      else $error("A cell write produced a read-stage word.");

   a_stalled_read_holds: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !blend_ready) |=> $stable(bank_rdata))
      else $error("Bank read data changed while the read stage was stalled.");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("More than one bank was written in one cycle.");

endmodule
